// ===== sv/fmws_pkg.sv =====
// Shared types, constants and the weight table for the flag-matched
// weighted selector. No dependencies.
`timescale 1ns / 1ps

package fmws_pkg;

    localparam int TABLE_DEPTH_DEF = 64;
    localparam int MAX_MATCH_DEF   = 11;

    localparam int OPCODE_W = 2;
    localparam int INDEX_W  = 6;
    localparam int WORD_W   = 32;
    localparam int FRAC_W   = 17;
    localparam int COUNT_W  = 7;
    localparam int TOTAL_W  = 4;
    localparam int STATUS_W = 2;

    localparam logic [OPCODE_W-1:0] OP_WRITE = 2'd0;
    localparam logic [OPCODE_W-1:0] OP_QUERY = 2'd1;
    localparam logic [OPCODE_W-1:0] OP_INVAL = 2'd2;

    localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] ST_INVALID  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NOMATCH  = 2'd2;
    localparam logic [STATUS_W-1:0] ST_OVERFLOW = 2'd3;

    localparam logic [WORD_W-1:0] WEIGHT_MASK = 32'h0000_0007;
    localparam logic [FRAC_W-1:0] ONE_Q16     = 17'h1_0000;

    typedef enum logic [1:0] {
        RES_ZERO,
        RES_INVALID,
        RES_QUERY
    } res_sel_t;

    typedef struct packed {
        logic     accept;
        logic     clr_step;
        logic     walk_eval;
        logic     mul;
        logic     scan_eval;
        logic     res_load;
        res_sel_t res_sel;
    } ctl_cmd_t;

    typedef struct packed {
        logic is_query;
        logic tbl_valid;
        logic clr_last;
        logic walk_last;
        logic scan_hit;
        logic out_free;
    } dp_sts_t;

    // Q1.16 product of 0.1 (bit 2), 0.33 (bit 1) and 0.5 (bit 0), rounded
    function automatic logic [FRAC_W-1:0] weight_q16(input logic [2:0] code);
        logic [FRAC_W-1:0] w;
        case (code)
            3'd0:    w = 17'd65536;
            3'd1:    w = 17'd32768;
            3'd2:    w = 17'd21627;
            3'd3:    w = 17'd10813;
            3'd4:    w = 17'd6554;
            3'd5:    w = 17'd3277;
            3'd6:    w = 17'd2163;
            3'd7:    w = 17'd1081;
            default: w = 17'd0;
        endcase
        return w;
    endfunction

endpackage

// ===== sv/fmws_if.sv =====
// Request and response channel interfaces for the selector.
// Depends on fmws_pkg for field widths.
`timescale 1ns / 1ps

interface fmws_req_if;
    logic                             valid;
    logic                             ready;
    logic [fmws_pkg::OPCODE_W-1:0]    opcode;
    logic [fmws_pkg::INDEX_W-1:0]     entry_index;
    logic [fmws_pkg::WORD_W-1:0]      entry_flags;
    logic [fmws_pkg::WORD_W-1:0]      entry_offset;
    logic [fmws_pkg::WORD_W-1:0]      variant_id;
    logic [fmws_pkg::FRAC_W-1:0]      rand_fraction;

    modport source (
        output valid, opcode, entry_index, entry_flags, entry_offset, variant_id,
               rand_fraction,
        input  ready
    );
    modport sink (
        input  valid, opcode, entry_index, entry_flags, entry_offset, variant_id,
               rand_fraction,
        output ready
    );
endinterface

interface fmws_rsp_if;
    logic                             valid;
    logic                             ready;
    logic [fmws_pkg::WORD_W-1:0]      selected_offset;
    logic [fmws_pkg::COUNT_W-1:0]     variation_count;
    logic [fmws_pkg::TOTAL_W-1:0]     match_total;
    logic [fmws_pkg::STATUS_W-1:0]    status;

    modport source (
        output valid, selected_offset, variation_count, match_total, status,
        input  ready
    );
    modport sink (
        input  valid, selected_offset, variation_count, match_total, status,
        output ready
    );
endinterface

// ===== sv/fmws_ctrl.sv =====
// Sequencing state machine: clearing pass, table walk, weighted pick, result.
// Depends on fmws_pkg for command and status structs.
`timescale 1ns / 1ps

module fmws_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    input  fmws_pkg::dp_sts_t  sts,
    output logic               req_ready,
    output fmws_pkg::ctl_cmd_t cmd
);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_WALK_RD,
        S_WALK_EV,
        S_MUL,
        S_SCAN_RD,
        S_SCAN_EV,
        S_DONE
    } state_t;

    state_t              state_reg, state_next;
    fmws_pkg::res_sel_t  sel_reg, sel_next;

    always_comb
    begin
        state_next    = state_reg;
        sel_next      = sel_reg;
        req_ready     = 1'b0;
        cmd           = '0;
        cmd.res_sel   = sel_reg;
        case (state_reg)
            S_CLEAR:
            begin
                cmd.clr_step = 1'b1;
                if (sts.clr_last)
                    state_next = S_IDLE;
            end
            S_IDLE:
            begin
                req_ready  = 1'b1;
                cmd.accept = req_valid;
                if (req_valid)
                begin
                    if (sts.is_query && sts.tbl_valid)
                    begin
                        state_next = S_WALK_RD;
                        sel_next   = fmws_pkg::RES_QUERY;
                    end
                    else
                    begin
                        state_next = S_DONE;
                        sel_next   = sts.is_query ? fmws_pkg::RES_INVALID
                                                  : fmws_pkg::RES_ZERO;
                    end
                end
            end
            S_WALK_RD:
                state_next = S_WALK_EV;
            S_WALK_EV:
            begin
                cmd.walk_eval = 1'b1;
                state_next    = sts.walk_last ? S_MUL : S_WALK_RD;
            end
            // match store read of slot 0 is in flight during the multiply
            S_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = S_SCAN_EV;
            end
            S_SCAN_RD:
                state_next = S_SCAN_EV;
            S_SCAN_EV:
            begin
                cmd.scan_eval = 1'b1;
                state_next    = sts.scan_hit ? S_DONE : S_SCAN_RD;
            end
            S_DONE:
            begin
                if (sts.out_free)
                begin
                    cmd.res_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            sel_reg   <= fmws_pkg::RES_ZERO;
        end
        else
        begin
            state_reg <= state_next;
            sel_reg   <= sel_next;
        end
    end

endmodule

// ===== sv/fmws_dp.sv =====
// Datapath: entry table memory, match store, walk counters, weight sum,
// pick multiplier and output register. Depends on fmws_pkg.
`timescale 1ns / 1ps

module fmws_dp #(
    parameter int TABLE_DEPTH = fmws_pkg::TABLE_DEPTH_DEF,
    parameter int MAX_MATCH   = fmws_pkg::MAX_MATCH_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  fmws_pkg::ctl_cmd_t              cmd,
    output fmws_pkg::dp_sts_t               sts,
    input  logic [fmws_pkg::OPCODE_W-1:0]   opcode,
    input  logic [fmws_pkg::INDEX_W-1:0]    entry_index,
    input  logic [fmws_pkg::WORD_W-1:0]     entry_flags,
    input  logic [fmws_pkg::WORD_W-1:0]     entry_offset,
    input  logic [fmws_pkg::WORD_W-1:0]     variant_id,
    input  logic [fmws_pkg::FRAC_W-1:0]     rand_fraction,
    input  logic                            rsp_ready,
    output logic                            rsp_valid,
    output logic [fmws_pkg::WORD_W-1:0]     selected_offset,
    output logic [fmws_pkg::COUNT_W-1:0]    variation_count,
    output logic [fmws_pkg::TOTAL_W-1:0]    match_total,
    output logic [fmws_pkg::STATUS_W-1:0]   status
);

    localparam int AW  = $clog2(TABLE_DEPTH);
    localparam int CW  = $clog2(TABLE_DEPTH + 1);
    localparam int XW  = (AW > fmws_pkg::INDEX_W) ? AW : fmws_pkg::INDEX_W;
    localparam int MAW = (MAX_MATCH > 1) ? $clog2(MAX_MATCH) : 1;
    localparam int FW  = $clog2(MAX_MATCH + 1);
    localparam int SW  = $clog2(MAX_MATCH * 65536 + 1);
    localparam int TW  = SW + fmws_pkg::FRAC_W;
    localparam int EW  = 2 * fmws_pkg::WORD_W;

    // entry table: {flags, offset}
    logic [EW-1:0]              tbl_mem [TABLE_DEPTH];
    logic [EW-1:0]              tbl_rd_reg;
    logic [fmws_pkg::WORD_W-1:0] off_mem [MAX_MATCH];
    logic [SW-1:0]              sum_mem [MAX_MATCH];
    logic [fmws_pkg::WORD_W-1:0] off_rd_reg;
    logic [SW-1:0]              sum_rd_reg;

    logic                       tbl_valid_reg;
    logic [CW-1:0]              i_reg;
    logic [MAW-1:0]             j_reg;
    logic [FW-1:0]              found_reg;
    logic [SW-1:0]              total_reg;
    logic [fmws_pkg::WORD_W-1:0] matched_reg;
    logic                       overflow_reg;
    logic [CW-1:0]              count_reg;
    logic [fmws_pkg::WORD_W-1:0] id_reg;
    logic [fmws_pkg::FRAC_W-1:0] rnd_reg;
    logic [TW-1:0]              target_reg;

    logic                       out_valid_reg;
    logic [fmws_pkg::WORD_W-1:0] out_off_reg;
    logic [fmws_pkg::COUNT_W-1:0] out_count_reg;
    logic [fmws_pkg::TOTAL_W-1:0] out_total_reg;
    logic [fmws_pkg::STATUS_W-1:0] out_status_reg;

    logic [XW-1:0]              idx_ext;
    logic                       in_range;
    logic                       wr_en;
    logic                       tbl_we;
    logic [AW-1:0]              tbl_wa;
    logic [EW-1:0]              tbl_wd;
    logic [fmws_pkg::WORD_W-1:0] rd_flags;
    logic [fmws_pkg::WORD_W-1:0] rd_off;
    logic [fmws_pkg::WORD_W-1:0] req_flags;
    logic                       hit;
    logic                       take;
    logic [SW-1:0]              total_new;
    logic                       term;
    logic                       idx_last;
    logic [fmws_pkg::FRAC_W-1:0] rnd_sat;
    logic [FW-1:0]              j_ext;
    logic                       scan_last;
    logic                       out_free;

    assign idx_ext  = XW'(entry_index);
    assign in_range = 32'(entry_index) < 32'(TABLE_DEPTH);
    assign wr_en    = cmd.accept && (opcode == fmws_pkg::OP_WRITE) && in_range;

    assign tbl_we = wr_en || cmd.clr_step;
    assign tbl_wa = cmd.clr_step ? i_reg[AW-1:0] : idx_ext[AW-1:0];
    assign tbl_wd = cmd.clr_step ? '0 : {entry_flags, entry_offset};

    assign rd_flags  = tbl_rd_reg[EW-1:fmws_pkg::WORD_W];
    assign rd_off    = tbl_rd_reg[fmws_pkg::WORD_W-1:0];
    assign req_flags = rd_flags & ~fmws_pkg::WEIGHT_MASK;
    assign hit       = ((req_flags & id_reg) == req_flags)
                    && ((found_reg == '0) || (matched_reg == req_flags));
    assign take      = hit && (found_reg < FW'(MAX_MATCH));
    assign total_new = total_reg + SW'(fmws_pkg::weight_q16(rd_flags[2:0]));
    assign term      = (rd_flags == '0);
    assign idx_last  = (i_reg == CW'(TABLE_DEPTH - 1));

    assign rnd_sat   = (rnd_reg > fmws_pkg::ONE_Q16) ? fmws_pkg::ONE_Q16 : rnd_reg;
    assign j_ext     = FW'(j_reg);
    assign scan_last = ((j_ext + FW'(1)) == found_reg);
    assign out_free  = !out_valid_reg || rsp_ready;

    always_comb
    begin
        sts.is_query  = (opcode == fmws_pkg::OP_QUERY);
        sts.tbl_valid = tbl_valid_reg;
        sts.clr_last  = idx_last;
        sts.walk_last = term || idx_last;
        sts.scan_hit  = (found_reg == '0) || scan_last
                     || (target_reg <= TW'({sum_rd_reg, 16'h0000}));
        sts.out_free  = out_free;
    end

    // memories
    always_ff @(posedge clk)
    begin
        if (tbl_we)
            tbl_mem[tbl_wa] <= tbl_wd;
        tbl_rd_reg <= tbl_mem[i_reg[AW-1:0]];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.walk_eval && take)
        begin
            off_mem[found_reg[MAW-1:0]] <= rd_off;
            sum_mem[found_reg[MAW-1:0]] <= total_new;
        end
        off_rd_reg <= off_mem[j_reg];
        sum_rd_reg <= sum_mem[j_reg];
    end

    // control counters and flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tbl_valid_reg <= 1'b0;
            i_reg         <= '0;
            j_reg         <= '0;
            found_reg     <= '0;
            overflow_reg  <= 1'b0;
        end
        else
        begin
            if (wr_en)
                tbl_valid_reg <= 1'b1;
            else if (cmd.accept && (opcode == fmws_pkg::OP_INVAL))
                tbl_valid_reg <= 1'b0;

            if (cmd.accept)
            begin
                i_reg        <= '0;
                j_reg        <= '0;
                found_reg    <= '0;
                overflow_reg <= 1'b0;
            end
            else
            begin
                if (cmd.clr_step || (cmd.walk_eval && !term && !idx_last))
                    i_reg <= i_reg + CW'(1);
                if (cmd.walk_eval && take)
                    found_reg <= found_reg + FW'(1);
                if (cmd.walk_eval && hit && !take)
                    overflow_reg <= 1'b1;
                if (cmd.scan_eval && !sts.scan_hit)
                    j_reg <= j_reg + MAW'(1);
            end
        end
    end

    // query payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            id_reg    <= variant_id;
            rnd_reg   <= rand_fraction;
            total_reg <= '0;
        end
        if (cmd.walk_eval)
        begin
            if (take)
            begin
                total_reg   <= total_new;
                matched_reg <= req_flags;
            end
            if (term)
                count_reg <= i_reg;
            else if (idx_last)
                count_reg <= CW'(TABLE_DEPTH);
        end
        if (cmd.mul)
            target_reg <= TW'(rnd_sat) * TW'(total_reg);
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.res_load)
            out_valid_reg <= 1'b1;
        else if (rsp_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.res_load)
        begin
            case (cmd.res_sel)
                fmws_pkg::RES_INVALID:
                begin
                    out_off_reg    <= '0;
                    out_count_reg  <= '0;
                    out_total_reg  <= '0;
                    out_status_reg <= fmws_pkg::ST_INVALID;
                end
                fmws_pkg::RES_QUERY:
                begin
                    out_count_reg <= fmws_pkg::COUNT_W'(count_reg);
                    if (found_reg == '0)
                    begin
                        out_off_reg    <= '0;
                        out_total_reg  <= '0;
                        out_status_reg <= fmws_pkg::ST_NOMATCH;
                    end
                    else
                    begin
                        out_off_reg    <= off_rd_reg;
                        out_total_reg  <= fmws_pkg::TOTAL_W'(found_reg);
                        out_status_reg <= overflow_reg ? fmws_pkg::ST_OVERFLOW
                                                       : fmws_pkg::ST_OK;
                    end
                end
                default:
                begin
                    out_off_reg    <= '0;
                    out_count_reg  <= '0;
                    out_total_reg  <= '0;
                    out_status_reg <= fmws_pkg::ST_OK;
                end
            endcase
        end
    end

    assign rsp_valid       = out_valid_reg;
    assign selected_offset = out_off_reg;
    assign variation_count = out_count_reg;
    assign match_total     = out_total_reg;
    assign status          = out_status_reg;

`ifndef SYNTHESIS
    a_found_bound: assert property (@(posedge clk) disable iff (!rst_n)
        found_reg <= FW'(MAX_MATCH))
        else $error("match count beyond store depth");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.res_load |-> (!out_valid_reg || rsp_ready))
        else $error("result loaded over an untaken result");

    a_single_write: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.clr_step |-> !wr_en)
        else $error("table write during clearing pass");

    a_scan_range: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.scan_eval && (found_reg != '0)) |-> (j_ext < found_reg))
        else $error("scan past last stored match");

    a_total_kept: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.scan_eval |=> $stable(total_reg))
        else $error("weight total changed during scan");
`endif

endmodule

// ===== sv/flag_matched_weighted_selector_top.sv =====
// Flag-matched weighted selector, top level. Uses fmws_pkg, fmws_if, fmws_ctrl, fmws_dp.
// Write, invalidate and unused items: result registered 1 cycle after the transfer.
// Query: per entry walked, a table read (which sets the pace) and an evaluation; a multiply;
// per stored match scanned, a read and an evaluation (the first read overlaps the multiply); a load.
// One item in work; the load waits for a free output, the next transfer can follow in the next cycle.
// Reset: a clearing pass over every table entry zeroes the table with req.ready low.
`timescale 1ns / 1ps

module flag_matched_weighted_selector_top #(
    parameter int TABLE_DEPTH = fmws_pkg::TABLE_DEPTH_DEF,
    parameter int MAX_MATCH   = fmws_pkg::MAX_MATCH_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    fmws_req_if.sink   req,
    fmws_rsp_if.source rsp
);

    fmws_pkg::ctl_cmd_t ctl_cmd;
    fmws_pkg::dp_sts_t  dp_sts;
    logic               req_ready;

    assign req.ready = req_ready;

    fmws_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .sts       (dp_sts),
        .req_ready (req_ready),
        .cmd       (ctl_cmd)
    );

    fmws_dp #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .MAX_MATCH   (MAX_MATCH)
    ) u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (ctl_cmd),
        .sts             (dp_sts),
        .opcode          (req.opcode),
        .entry_index     (req.entry_index),
        .entry_flags     (req.entry_flags),
        .entry_offset    (req.entry_offset),
        .variant_id      (req.variant_id),
        .rand_fraction   (req.rand_fraction),
        .rsp_ready       (rsp.ready),
        .rsp_valid       (rsp.valid),
        .selected_offset (rsp.selected_offset),
        .variation_count (rsp.variation_count),
        .match_total     (rsp.match_total),
        .status          (rsp.status)
    );

endmodule
